// File: hdl/ctg_pkg.sv
// Shared types, widths and constants for the chirp tone generator.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
`default_nettype none

package ctg_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int PHASE_BITS   = 32;
  localparam int IDX_W        = $clog2(SINE_ENTRIES);

  localparam int START_W   = 31;
  localparam int STEP_W    = 32;
  localparam int CNT_W     = 16;
  localparam int PROG_W    = 25;
  localparam int PROG_FRAC = 24;
  localparam int VOL_W     = 16;
  localparam int INC_W     = 40;
  localparam int SMP_W     = 16;
  localparam int ENV_W     = 25;
  localparam int PROD_W    = 40;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [PROG_W-1:0] PROG_ONE  = PROG_W'(1) << PROG_FRAC;
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0]       FULL_SCALE  = 64'd32767;

  typedef enum logic [2:0] {
    REG_START_INC     = 3'd0,
    REG_INC_STEP      = 3'd1,
    REG_SAMPLE_COUNT  = 3'd2,
    REG_PROGRESS_STEP = 3'd3,
    REG_VOLUME        = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [START_W-1:0] start_increment;
    logic [STEP_W-1:0]  increment_step;
    logic [CNT_W-1:0]   sample_count;
    logic [PROG_W-1:0]  progress_step;
    logic [VOL_W-1:0]   volume;
  } ctg_cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [PROG_W-1:0]     progress;
    logic                  last;
  } ctg_job_t;

  typedef logic [SINE_ENTRIES-1:0][SMP_W-1:0] sine_tab_t;

  function automatic logic [SMP_W-1:0] quarter_sine(input logic [31:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    begin
      x    = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) / (2 * SINE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * x2) >> 30) / 156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 210;
      sum  = (sum > term) ? sum - term : 64'd0;
      v    = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
      if (v > FULL_SCALE) begin
        v = FULL_SCALE;
      end
      return v[SMP_W-1:0];
    end
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    begin
      for (int k = 0; k < SINE_ENTRIES; k++) begin
        tab[k] = quarter_sine(32'(k));
      end
      return tab;
    end
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// File: hdl/chirp_tone_generator_core.sv
// Chirp tone generator: each tick request on the input stream yields at most one
// 16-bit sample of a linearly swept, quadratically decaying sine tone.
// Input stream: in_tdata bit 0 is restart; 1 starts a new tone at sample zero.
// Output stream: out_tdata is the signed sample, out_tlast marks the tone's final
// sample. Ticks with no tone running are taken and give no result.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16
// (start increment, increment step, sample count, progress step, volume). Write
// them only while no request is in flight.
// Each job goes through the job queue and then the pipeline stages to out_tvalid.
// Throughput: one request per cycle unless stalled, sustained by the front end's
// accumulators and the four-stage sample pipeline (table read, two multiplies,
// output register). A four-entry job queue sits between front end and pipeline.
// Stalls: when out_tvalid is high and out_tready is low the pipeline holds;
// requests are still taken until the queue fills, then in_tready drops.
// Reset: synchronous; clears the tone state, queue and pipeline and loads the
// register defaults. The sine table is constant and needs no fill.
`default_nettype none

module chirp_tone_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,     // [0] restart
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ctg_pkg::SMP_W-1:0]     out_tdata,    // [15:0] sample
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [ctg_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [ctg_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import ctg_pkg::*;

  ctg_cfg_t cfg;
  ctg_job_t push_job, head_job;
  logic     push, pop, q_full, q_empty;

  ctg_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ctg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_ready   (in_tready),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .job        (push_job)
  );

  ctg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  ctg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .pop        (pop),
    .volume     (cfg.volume),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

// File: hdl/ctg_cfg_regs.sv
// Register bank behind the APB-style configuration port.
// Depends on ctg_pkg for the register map and the configuration struct.
`default_nettype none

module ctg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctg_pkg::ADDR_W-1:0]    paddr,
  input  logic [ctg_pkg::DATA_W-1:0]    pwdata,
  output logic [ctg_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output ctg_pkg::ctg_cfg_t             cfg
);
  import ctg_pkg::*;

  ctg_cfg_t cfg_r;
  ctg_cfg_t cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_INC:     cfg_nxt.start_increment = pwdata[START_W-1:0];
        REG_INC_STEP:      cfg_nxt.increment_step  = pwdata[STEP_W-1:0];
        REG_SAMPLE_COUNT:  cfg_nxt.sample_count    = pwdata[CNT_W-1:0];
        REG_PROGRESS_STEP: cfg_nxt.progress_step   = pwdata[PROG_W-1:0];
        REG_VOLUME:        cfg_nxt.volume          = pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_INC:     prdata = DATA_W'(cfg_r.start_increment);
      REG_INC_STEP:      prdata = DATA_W'(cfg_r.increment_step);
      REG_SAMPLE_COUNT:  prdata = DATA_W'(cfg_r.sample_count);
      REG_PROGRESS_STEP: prdata = DATA_W'(cfg_r.progress_step);
      REG_VOLUME:        prdata = DATA_W'(cfg_r.volume);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_increment <= '0;
      cfg_r.increment_step  <= '0;
      cfg_r.sample_count    <= CNT_W'(1);
      cfg_r.progress_step   <= PROG_ONE;
      cfg_r.volume          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctg_front.sv
// Front end: accepts tick requests, keeps the tone state and queues sample jobs.
// Depends on ctg_pkg for the configuration and job structs.
`default_nettype none

module ctg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_restart,
  output logic              in_ready,
  input  ctg_pkg::ctg_cfg_t cfg,
  input  logic              q_full,
  output logic              push,
  output ctg_pkg::ctg_job_t job
);
  import ctg_pkg::*;

  logic [PHASE_BITS-1:0] phase_r, phase_nxt, cur_phase, phase_new;
  logic [INC_W-1:0]      inc_r, inc_nxt, cur_inc, step_ext;
  logic [CNT_W-1:0]      idx_r, idx_nxt, cur_idx;
  logic [PROG_W-1:0]     prog_r, prog_nxt, cur_prog, prog_dec;
  logic                  active_r, active_nxt, cur_active;
  logic [CNT_W:0]        idx_inc;
  logic                  accept;
  logic                  last;

  assign in_ready = ~q_full;
  assign accept   = in_valid & in_ready;

  always_comb begin
    cur_phase  = in_restart ? '0 : phase_r;
    cur_inc    = in_restart
                 ? {{(INC_W-START_W-8){1'b0}}, cfg.start_increment, 8'h00} : inc_r;
    cur_idx    = in_restart ? '0 : idx_r;
    cur_prog   = in_restart ? PROG_ONE : prog_r;
    cur_active = in_restart ? (cfg.sample_count != '0) : active_r;

    phase_new = cur_phase + cur_inc[INC_W-1 -: PHASE_BITS];
    idx_inc   = {1'b0, cur_idx} + (CNT_W+1)'(1);
    last      = idx_inc >= {1'b0, cfg.sample_count};
    step_ext  = {{(INC_W-STEP_W){cfg.increment_step[STEP_W-1]}}, cfg.increment_step};
    prog_dec  = (cur_prog > cfg.progress_step) ? cur_prog - cfg.progress_step : '0;

    push         = accept & cur_active;
    job.phase    = phase_new;
    job.progress = cur_prog;
    job.last     = last;

    phase_nxt  = phase_r;
    inc_nxt    = inc_r;
    idx_nxt    = idx_r;
    prog_nxt   = prog_r;
    active_nxt = active_r;
    if (accept) begin
      phase_nxt  = cur_phase;
      inc_nxt    = cur_inc;
      idx_nxt    = cur_idx;
      prog_nxt   = cur_prog;
      active_nxt = cur_active;
      if (cur_active) begin
        phase_nxt  = phase_new;
        inc_nxt    = cur_inc + step_ext;
        idx_nxt    = idx_inc[CNT_W-1:0];
        prog_nxt   = prog_dec;
        active_nxt = ~last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= '0;
      inc_r    <= '0;
      idx_r    <= '0;
      prog_r   <= '0;
      active_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      inc_r    <= inc_nxt;
      idx_r    <= idx_nxt;
      prog_r   <= prog_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctg_queue.sv
// Short job queue between the front end and the sample pipeline.
// Depends on ctg_pkg for the job struct and the queue depth.
`default_nettype none

module ctg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ctg_pkg::ctg_job_t push_job,
  input  logic              pop,
  output ctg_pkg::ctg_job_t head_job,
  output logic              full,
  output logic              empty
);
  import ctg_pkg::*;

  ctg_job_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full     = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctg_back.sv
// Sample pipeline: sine table read, envelope, volume scaling and output register.
// Depends on ctg_pkg for the job struct and the sine table.
`default_nettype none

module ctg_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  ctg_pkg::ctg_job_t         q_job,
  output logic                      pop,
  input  logic [ctg_pkg::VOL_W-1:0] volume,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ctg_pkg::SMP_W-1:0] out_sample,
  output logic                      out_last
);
  import ctg_pkg::*;

  logic                  en;
  logic [1:0]            quad;
  logic [IDX_W-1:0]      raw_idx, rom_addr;
  logic [2*PROG_W-1:0]   prog_sq;
  logic [SMP_W+ENV_W-1:0] prod1;
  logic [PROD_W+VOL_W-1:0] prod2;

  logic                  s0_valid_r, s1_valid_r, s2_valid_r, out_valid_r;
  logic [SMP_W-1:0]      s0_mag_r;
  logic [ENV_W-1:0]      s0_env_r;
  logic                  s0_neg_r, s0_last_r;
  logic [PROD_W-1:0]     s1_prod_r;
  logic                  s1_neg_r, s1_last_r;
  logic [SMP_W-1:0]      s2_mag_r;
  logic                  s2_neg_r, s2_last_r;
  logic [SMP_W-1:0]      out_sample_r;
  logic                  out_last_r;

  assign en  = ~out_valid_r | out_ready;
  assign pop = en & ~q_empty;

  assign quad     = q_job.phase[PHASE_BITS-1 -: 2];
  assign raw_idx  = q_job.phase[PHASE_BITS-3 -: IDX_W];
  assign rom_addr = quad[0] ? ~raw_idx : raw_idx;
  assign prog_sq  = q_job.progress * q_job.progress;
  assign prod1    = s0_mag_r * s0_env_r;
  assign prod2    = s1_prod_r * volume;

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag_r     <= SINE_TAB[rom_addr];
      s0_env_r     <= prog_sq[PROG_FRAC +: ENV_W];
      s0_neg_r     <= quad[1];
      s0_last_r    <= q_job.last;
      s1_prod_r    <= prod1[PROD_W-1:0];
      s1_neg_r     <= s0_neg_r;
      s1_last_r    <= s0_last_r;
      s2_mag_r     <= prod2[PROD_W +: SMP_W];
      s2_neg_r     <= s1_neg_r;
      s2_last_r    <= s1_last_r;
      out_sample_r <= s2_neg_r ? SMP_W'(-s2_mag_r) : s2_mag_r;
      out_last_r   <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r  <= ~q_empty;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctg_checker.sv
// Port-level checks for the chirp tone generator, bound to the top level.
// Depends on ctg_pkg for port widths and register indexes.
`default_nettype none

module ctg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ctg_pkg::SMP_W-1:0]  out_tdata,
  input logic                       out_tlast,
  input logic                       cfg_psel,
  input logic                       cfg_penable,
  input logic                       cfg_pwrite,
  input logic [ctg_pkg::ADDR_W-1:0] cfg_paddr,
  input logic [ctg_pkg::DATA_W-1:0] cfg_pwdata,
  input logic [ctg_pkg::DATA_W-1:0] cfg_prdata,
  input logic                       cfg_pready
);
  import ctg_pkg::*;

  logic [ADDR_W-1:0] cnt_addr;
  logic              cnt_write;

  assign cnt_addr  = {REG_SAMPLE_COUNT, 2'b00};
  assign cnt_write = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                     & (cfg_paddr == cnt_addr);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_reset_in_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != 16'h8000)
    else $error("sample outside symmetric range");

  a_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cnt_write) && cfg_psel && !cfg_pwrite && cfg_paddr == cnt_addr
    |-> cfg_prdata == DATA_W'($past(cfg_pwdata[CNT_W-1:0])))
    else $error("sample count readback mismatch");

endmodule

bind chirp_tone_generator_core ctg_checker u_ctg_checker (.*);

`default_nettype wire
